/* rtl/skset_pkg.sv */
// ----------------------------------------------------------------------------
// skset_pkg
// shared types and constants for the sorted key set
// ----------------------------------------------------------------------------
package skset_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_DEL = 2'd1,
        OP_HAS = 2'd2
    } t_opcode;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

/* rtl/skset_cell.sv */
// ----------------------------------------------------------------------------
// skset_cell
// one slot of the sorted chain: compares against the request key and shifts
// its key toward or from its neighbors on insert or delete
// ----------------------------------------------------------------------------
module skset_cell #(
    parameter int KEY_BITS = skset_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  skset_pkg::t_cell_ctrl      i_ctrl,
    input  logic signed [KEY_BITS-1:0] i_req_key,
    input  logic signed [KEY_BITS-1:0] i_prev_key,
    input  logic                       i_prev_valid,
    input  logic                       i_prev_lt,
    input  logic signed [KEY_BITS-1:0] i_next_key,
    input  logic                       i_next_valid,
    output logic signed [KEY_BITS-1:0] o_key,
    output logic                       o_valid,
    output logic                       o_lt,
    output logic                       o_eq
);

    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic                       r_valid, n_valid;
    logic                       r_lt;
    logic                       r_eq;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctrl.ins && !r_lt) begin
            if (i_prev_lt) begin
                n_key   = i_req_key;
                n_valid = 1'b1;
            end else begin
                n_key   = i_prev_key;
                n_valid = i_prev_valid;
            end
        end else if (i_ctrl.del && !r_lt) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctrl.cmp) begin
            r_lt <= r_valid && (r_key < i_req_key);
            r_eq <= r_valid && (r_key == i_req_key);
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

/* rtl/skset_or_tree.sv */
// ----------------------------------------------------------------------------
// skset_or_tree
// three-level registered or-reduction of the per-cell match flags
// ----------------------------------------------------------------------------
module skset_or_tree #(
    parameter int N = skset_pkg::CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic [N-1:0] i_bits,
    output logic         o_any
);

    localparam int LOG_N = $clog2(N);
    localparam int GL    = (LOG_N + 2) / 3;
    localparam int G     = 1 << GL;
    localparam int L1    = (N + G - 1) / G;
    localparam int L2    = (L1 + G - 1) / G;

    logic [L1-1:0] r_l1, n_l1;
    logic [L2-1:0] r_l2, n_l2;
    logic          r_l3;

    always_comb begin
        n_l1 = '0;
        for (int j = 0; j < L1; j++) begin
            for (int b = 0; b < G; b++) begin
                if (j * G + b < N) begin
                    n_l1[j] = n_l1[j] | i_bits[j * G + b];
                end
            end
        end
    end

    always_comb begin
        n_l2 = '0;
        for (int j = 0; j < L2; j++) begin
            for (int b = 0; b < G; b++) begin
                if (j * G + b < L1) begin
                    n_l2[j] = n_l2[j] | r_l1[j * G + b];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1 <= n_l1;
        r_l2 <= n_l2;
        r_l3 <= |r_l2;
    end

    assign o_any = r_l3;

endmodule

/* rtl/sorted_key_set.sv */
// ----------------------------------------------------------------------------
// sorted_key_set
// set of distinct signed keys held in ascending order in a chain of cells
// ----------------------------------------------------------------------------
// Each request (add, remove or membership test) is accepted when the block is
// idle and passes from transfer to result in order: in S_CMP every cell
// compares its key against the request key, in S_T1 to S_T3 the registered
// or-tree finds a matching cell, and in S_UPD the chain shifts by one slot
// toward the insertion point or closes the gap of a deletion. The next request
// is accepted in the cycle after that, so a new request is not taken before the
// last one is through, even while the previous result waits in the output
// register; a result is only formed once the output register is free. Reset
// clears all slot valid bits at once, so the set is empty right after reset
// with no clearing pass.
module sorted_key_set #(
    parameter int CAPACITY = skset_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skset_pkg::KEY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_opcode,
    input  logic signed [KEY_BITS-1:0]          i_key,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_ok,
    output logic                                o_set_full,
    output logic [$clog2(CAPACITY+1)-1:0]       o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMP  = 6'b000010,
        S_T1   = 6'b000100,
        S_T2   = 6'b001000,
        S_T3   = 6'b010000,
        S_UPD  = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0]                 r_op;
    logic signed [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_out_valid, n_out_valid;
    logic                       r_ok, n_ok;
    logic                       r_full, n_full;
    logic [CNT_W-1:0]           r_out_count, n_out_count;

    logic                       w_in_xfer;
    logic                       w_commit;
    logic                       w_present;
    logic                       w_is_full;
    logic                       w_ins;
    logic                       w_del;
    skset_pkg::t_cell_ctrl      w_ctrl;

    logic signed [KEY_BITS-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0]        w_cell_valid;
    logic [CAPACITY-1:0]        w_cell_lt;
    logic [CAPACITY-1:0]        w_cell_eq;

    assign w_in_xfer = i_in_valid && !o_in_stall;
    assign w_commit  = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);
    assign w_is_full = (r_count == CNT_W'(CAPACITY));
    assign w_ins     = (r_op == skset_pkg::OP_ADD) && !w_present && !w_is_full;
    assign w_del     = (r_op == skset_pkg::OP_DEL) && w_present;

    always_comb begin
        w_ctrl.cmp = (r_state == S_CMP);
        w_ctrl.ins = w_commit && w_ins;
        w_ctrl.del = w_commit && w_del;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_T1;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_T3;
            S_T3:   n_state = S_UPD;
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_ok        = r_ok;
        n_full      = r_full;
        n_out_count = r_out_count;
        if (w_commit) begin
            if (w_ins) begin
                n_count = r_count + CNT_W'(1);
            end else if (w_del) begin
                n_count = r_count - CNT_W'(1);
            end
            n_out_valid = 1'b1;
            n_ok        = w_ins || w_del || ((r_op == skset_pkg::OP_HAS) && w_present);
            n_full      = (r_op == skset_pkg::OP_ADD) && !w_present && w_is_full;
            n_out_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        r_ok        <= n_ok;
        r_full      <= n_full;
        r_out_count <= n_out_count;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [KEY_BITS-1:0] w_prev_key;
        logic                       w_prev_valid;
        logic                       w_prev_lt;
        logic signed [KEY_BITS-1:0] w_next_key;
        logic                       w_next_valid;

        if (i == 0) begin : g_head
            assign w_prev_key   = '0;
            assign w_prev_valid = 1'b0;
            assign w_prev_lt    = 1'b1;
        end else begin : g_body
            assign w_prev_key   = w_cell_key[i-1];
            assign w_prev_valid = w_cell_valid[i-1];
            assign w_prev_lt    = w_cell_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next_key   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_key   = w_cell_key[i+1];
            assign w_next_valid = w_cell_valid[i+1];
        end

        skset_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_req_key    (r_key),
            .i_prev_key   (w_prev_key),
            .i_prev_valid (w_prev_valid),
            .i_prev_lt    (w_prev_lt),
            .i_next_key   (w_next_key),
            .i_next_valid (w_next_valid),
            .o_key        (w_cell_key[i]),
            .o_valid      (w_cell_valid[i]),
            .o_lt         (w_cell_lt[i]),
            .o_eq         (w_cell_eq[i])
        );
    end

    skset_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_bits (w_cell_eq),
        .o_any  (w_present)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_set_full    = r_full;
    assign o_entry_count = r_out_count;

endmodule

/* rtl/skset_checker.sv */
// ----------------------------------------------------------------------------
// skset_checker
// port-level checks on the sorted key set, bound to the top level
// ----------------------------------------------------------------------------
module skset_checker #(
    parameter int CAPACITY = skset_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skset_pkg::KEY_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_ok,
    input logic                                o_set_full,
    input logic [$clog2(CAPACITY+1)-1:0]       o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // a refused add never reports success
    a_full_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_set_full |-> !o_ok)
        else $error("set_full and ok both high");

    // a refused add only happens at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_set_full |-> o_entry_count == CNT_W'(CAPACITY))
        else $error("set_full below capacity");

    // one request at a time: busy right after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_ok)
            && $stable(o_set_full) && $stable(o_entry_count))
        else $error("stalled result changed");

endmodule

bind sorted_key_set skset_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
) u_skset_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_ok          (o_ok),
    .o_set_full    (o_set_full),
    .o_entry_count (o_entry_count)
);
